// ===== rtl/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int CHAR_COUNT_W = 16;
  localparam int CP_W         = 31;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CMP_W        = (COUNT_BITS > CHAR_COUNT_W) ? COUNT_BITS : CHAR_COUNT_W;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_OUTPUT = CFG_IDX_W'(1);

  localparam logic [CHAR_COUNT_W-1:0] MAX_CHARS_RESET = '1;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX       = '1;

  typedef enum logic [2:0] {
    BC_NUL,
    BC_ASCII,
    BC_LEAD,
    BC_CONT,
    BC_BAD
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [2:0]  lead_len;
    logic [6:0]  bits;
    logic        eos;
  } byte_item_t;

  typedef struct packed {
    logic [CP_W-1:0]         code_point;
    logic                    char_valid;
    logic                    is_error;
    logic                    is_last;
    logic [CHAR_COUNT_W-1:0] char_count;
  } dec_result_t;

endpackage

// ===== rtl/utf8_stream_decoder_core.sv =====
// Top level of the legacy six-byte UTF-8 stream decoder.
//
// chan | dir | handshake             | payload
// -----+-----+-----------------------+------------------------------------------------------
// in   | in  | in_valid / in_stall   | in_byte, end_of_string
// out  | out | out_valid / out_stall | code_point, char_valid, is_error, is_last, char_count
// cfg  | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte is classified on entry and lands in a two-entry queue at its accepting edge;
// the back end decodes the queue head and loads the result register, which drives
// out_valid. Sustained rate is one byte per cycle while no held result blocks the
// queue head; in_stall is high only while the queue holds two bytes, which happens once
// a held result blocks a head byte that gives a result of its own.
// Reset clears decode state and the queue; max_chars resets to 65535, narrow_output to 0.
module utf8_stream_decoder_core
  import u8d_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input bytes
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_byte,
  input  logic                    end_of_string,
  // decoded results
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CP_W-1:0]         code_point,
  output logic                    char_valid,
  output logic                    is_error,
  output logic                    is_last,
  output logic [CHAR_COUNT_W-1:0] char_count,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  byte_item_t  front_item;
  byte_item_t  head_item;
  logic        queue_full;
  logic        head_valid;
  logic        push;
  logic        pop;
  dec_result_t result;

  // Accept a byte whenever the queue has room.
  assign in_stall  = queue_full;
  assign push      = in_valid && !queue_full;
  assign cfg_ready = 1'b1;

  u8d_front u_front (
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .item          (front_item)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (head_valid),
    .item       (head_item),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result     (result)
  );

  // Unpack the result register onto the output ports.
  assign code_point = result.code_point;
  assign char_valid = result.char_valid;
  assign is_error   = result.is_error;
  assign is_last    = result.is_last;
  assign char_count = result.char_count;

endmodule

// ===== rtl/u8d_front.sv =====
// Front end: classifies each incoming byte and extracts its payload bits.
module u8d_front
  import u8d_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output byte_item_t item
);

  always_comb begin
    item.eos      = end_of_string;
    item.lead_len = 3'd0;
    item.bits     = in_byte[6:0];
    item.cls      = BC_BAD;
    if (in_byte == 8'h00) begin
      item.cls = BC_NUL;
    end else if (!in_byte[7]) begin
      item.cls = BC_ASCII;
    end else if (!in_byte[6]) begin
      item.cls  = BC_CONT;
      item.bits = {1'b0, in_byte[5:0]};
    end else if (!in_byte[5]) begin
      item.cls      = BC_LEAD;
      item.lead_len = 3'd1;
      item.bits     = {2'b0, in_byte[4:0]};
    end else if (!in_byte[4]) begin
      item.cls      = BC_LEAD;
      item.lead_len = 3'd2;
      item.bits     = {3'b0, in_byte[3:0]};
    end else if (!in_byte[3]) begin
      item.cls      = BC_LEAD;
      item.lead_len = 3'd3;
      item.bits     = {4'b0, in_byte[2:0]};
    end else if (!in_byte[2]) begin
      item.cls      = BC_LEAD;
      item.lead_len = 3'd4;
      item.bits     = {5'b0, in_byte[1:0]};
    end else if (!in_byte[1]) begin
      item.cls      = BC_LEAD;
      item.lead_len = 3'd5;
      item.bits     = {6'b0, in_byte[0]};
    end else begin
      // 0xFE and 0xFF never start a character
      item.cls = BC_BAD;
    end
  end

endmodule

// ===== rtl/u8d_queue.sv =====
// Two-entry queue of classified bytes between front and back end.
module u8d_queue
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  byte_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output byte_item_t head_item
);

  byte_item_t entry [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'(QUEUE_DEPTH));
  assign head_valid = (fill != 2'd0);
  assign head_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/u8d_back.sv =====
// Back end: decode state, configuration registers and the result register.
module u8d_back
  import u8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  byte_item_t            item,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output dec_result_t           result
);

  logic [CHAR_COUNT_W-1:0] max_chars;
  logic                    narrow_output;

  logic [2:0]            bytes_pending;
  logic [CP_W-1:0]       partial_value;
  logic [COUNT_BITS-1:0] decoded_count;
  logic                  halted;

  logic [2:0]            bytes_pending_next;
  logic [CP_W-1:0]       partial_value_next;
  logic [COUNT_BITS-1:0] decoded_count_next;
  logic                  halted_next;

  logic            has_res;
  dec_result_t     res;
  logic [CP_W-1:0] pv_shift;
  logic [CP_W-1:0] cp_src;
  logic [CP_W-1:0] cp_out;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic            at_capacity;
  logic            done_last;
  logic            do_complete;
  logic            do_fail;
  logic            do_final;

  assign pv_shift    = {partial_value[CP_W-7:0], item.bits[5:0]};
  assign cnt_inc     = (decoded_count != COUNT_MAX) ? decoded_count + 1'b1 : decoded_count;
  assign at_capacity = CMP_W'(decoded_count) >= CMP_W'(max_chars);
  assign done_last   = item.eos || (CMP_W'(cnt_inc) >= CMP_W'(max_chars));
  assign cp_out      = narrow_output ? CP_W'(cp_src[15:0]) : cp_src;

  // Classify the step: final without character, error, completed character, or no result.
  always_comb begin
    do_complete        = 1'b0;
    do_fail            = 1'b0;
    do_final           = 1'b0;
    cp_src             = pv_shift;
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    decoded_count_next = decoded_count;
    halted_next        = halted;
    if (halted) begin
      if (item.eos) begin
        halted_next = 1'b0;
        decoded_count_next = '0;
      end
    end else if (bytes_pending == 3'd0) begin
      if (item.cls == BC_NUL || at_capacity) begin
        do_final = 1'b1;
      end else if (item.cls == BC_ASCII) begin
        do_complete = 1'b1;
        cp_src      = CP_W'(item.bits);
      end else if (item.cls == BC_LEAD) begin
        if (item.eos) begin
          do_fail = 1'b1;
        end else begin
          bytes_pending_next = item.lead_len;
          partial_value_next = CP_W'(item.bits);
        end
      end else begin
        do_fail = 1'b1;
      end
    end else begin
      if (item.cls != BC_CONT) begin
        do_fail = 1'b1;
      end else if (bytes_pending == 3'd1) begin
        do_complete = 1'b1;
      end else if (item.eos) begin
        do_fail = 1'b1;
      end else begin
        bytes_pending_next = bytes_pending - 3'd1;
        partial_value_next = pv_shift;
      end
    end

    has_res = do_complete || do_fail || do_final;
    res.code_point = '0;
    res.char_valid = 1'b0;
    res.is_error   = do_fail;
    res.is_last    = 1'b1;
    res.char_count = CHAR_COUNT_W'(decoded_count);

    if (do_complete) begin
      res.code_point     = cp_out;
      res.char_valid     = 1'b1;
      res.is_last        = done_last;
      res.char_count     = CHAR_COUNT_W'(cnt_inc);
      decoded_count_next = cnt_inc;
    end
    if (has_res) begin
      bytes_pending_next = 3'd0;
      partial_value_next = '0;
      // A final result ends the string: clear at its end, else halt.
      if (res.is_last) begin
        if (item.eos) begin
          decoded_count_next = '0;
          halted_next        = 1'b0;
        end else begin
          halted_next = 1'b1;
        end
      end
    end
  end

  assign pop = item_valid && (!has_res || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars     <= MAX_CHARS_RESET;
      narrow_output <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_CHARS:     max_chars     <= cfg_data;
        CFG_NARROW_OUTPUT: narrow_output <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 3'd0;
      partial_value <= '0;
      decoded_count <= '0;
      halted        <= 1'b0;
    end else if (pop) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      decoded_count <= decoded_count_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && has_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      result <= res;
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    bytes_pending <= 3'd5)
    else $error("more than five continuation bytes pending");

  a_halt_idle: assert property (@(posedge clk) disable iff (rst)
    halted |-> (bytes_pending == 3'd0 && partial_value == '0))
    else $error("halted with a partial character");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.is_error) |-> (result.is_last && !result.char_valid))
    else $error("error item not final");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !(pop && has_res)) |=> (out_valid && $stable(result)))
    else $error("stalled result lost");

endmodule
